>>> rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// Used by every module in rtl/. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int DATA_W     = 16;
  localparam int CW         = 19;                 // t and unscaled components
  localparam int MAG_W      = CW - 1;
  localparam int RAD_W      = 33;                 // radicand and root working width
  localparam int ROOT_W     = 16;
  localparam int DIV_W      = 34;                 // dividend and remainder width
  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = DATA_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  // Load stage, root steps, divider setup, quotient steps.
  localparam int NST        = 1 + SQRT_STEPS + 1 + DIV_STEPS;

  typedef enum logic [1:0] {
    FORM_X = 2'd0,
    FORM_Y = 2'd1,
    FORM_Z = 2'd2,
    FORM_W = 2'd3
  } form_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] qw;
    logic signed [DATA_W-1:0] qx;
    logic signed [DATA_W-1:0] qy;
    logic signed [DATA_W-1:0] qz;
    logic [1:0]               form_used;
    logic                     invalid;
  } out_item_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    form_e                 form;
    logic                  invalid;
    logic [CW-1:0]         t;
    logic [3:0][CW-1:0]    c;
  } work_t;

endpackage
`default_nettype wire

>>> rtl/rmq_front.sv
// Front end: picks the form for an input matrix, forms t and the
// unscaled components and registers them. Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front import rmq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          wk_valid_o,
  input  wire logic     wk_full_i,
  output work_t         wk_data_o
);

  localparam logic signed [CW-1:0] ONE = CW'(1 << FRAC_BITS);

  logic  valid_q;
  work_t wk_q, wk_d;
  logic  take;

  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, t;

  always_comb begin
    e00 = CW'(in_data_i.m00);
    e01 = CW'(in_data_i.m01);
    e02 = CW'(in_data_i.m02);
    e10 = CW'(in_data_i.m10);
    e11 = CW'(in_data_i.m11);
    e12 = CW'(in_data_i.m12);
    e20 = CW'(in_data_i.m20);
    e21 = CW'(in_data_i.m21);
    e22 = CW'(in_data_i.m22);
    if (e22 < 0) begin
      if (e00 > e11) begin
        wk_d.form = FORM_X;
        t = ONE + e00 - e11 - e22;
        wk_d.c = {e20 + e02, e01 + e10, t, e21 - e12};
      end else begin
        wk_d.form = FORM_Y;
        t = ONE - e00 + e11 - e22;
        wk_d.c = {e12 + e21, t, e01 + e10, e02 - e20};
      end
    end else if (e00 < -e11) begin
      wk_d.form = FORM_Z;
      t = ONE - e00 - e11 + e22;
      wk_d.c = {t, e12 + e21, e02 + e20, e10 - e01};
    end else begin
      wk_d.form = FORM_W;
      t = ONE + e00 + e11 + e22;
      wk_d.c = {e10 - e01, e02 - e20, e21 - e12, t};
    end
    wk_d.t       = t;
    wk_d.invalid = (t <= 0);
  end

  assign in_stall_o = valid_q && wk_full_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      wk_q <= wk_d;
    end
  end

  assign wk_valid_o = valid_q;
  assign wk_data_o  = wk_q;

endmodule
`default_nettype wire

>>> rtl/rmq_queue.sv
// Short queue between the front end and the back end.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_queue import rmq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire work_t push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output work_t      pop_data_o
);

  work_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCNT_W'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

>>> rtl/rmq_back.sv
// Back end: pipelined integer square root, per-component restoring divide,
// rounding and saturation, and the output register. Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_back import rmq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      empty_i,
  input  wire work_t     wk_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  typedef struct packed {
    form_e                     form;
    logic                      invalid;
    logic [RAD_W-1:0]          v;
    logic [RAD_W-1:0]          res;
    logic [3:0]                neg;
    logic [3:0][MAG_W-1:0]     mag;
    logic [3:0]                sat;
    logic [3:0][DIV_W-1:0]     rem;
    logic [3:0][DIV_W-1:0]     quo;
  } stage_t;

  stage_t    st_q [NST];
  stage_t    st_d [NST];
  logic      vld_q [NST];
  logic      adv;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  function automatic stage_t load(work_t w);
    stage_t r;
    logic signed [CW-1:0] c;
    r = '0;
    r.form    = w.form;
    r.invalid = w.invalid;
    r.v       = w.invalid ? '0 : (RAD_W'(w.t[CW-2:0]) << FRAC_BITS);
    for (int k = 0; k < 4; k++) begin
      c = $signed(w.c[k]);
      r.neg[k] = c[CW-1];
      r.mag[k] = c[CW-1] ? MAG_W'(-c) : MAG_W'(c);
    end
    return r;
  endfunction

  function automatic stage_t root_step(stage_t x, int k);
    stage_t           r;
    logic [RAD_W-1:0] bit_v, trial;
    r     = x;
    bit_v = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    trial = x.res + bit_v;
    if (x.v >= trial) begin
      r.v   = x.v - trial;
      r.res = (x.res >> 1) + bit_v;
    end else begin
      r.res = x.res >> 1;
    end
    return r;
  endfunction

  function automatic stage_t div_setup(stage_t x);
    stage_t           r;
    logic [DIV_W-1:0] s, d, n;
    r = x;
    s = DIV_W'(x.res[ROOT_W-1:0]);
    d = s << 1;
    for (int k = 0; k < 4; k++) begin
      n = (DIV_W'(x.mag[k]) << FRAC_BITS) + s;
      r.sat[k] = (n >= (d << DIV_STEPS));
      r.rem[k] = n;
      r.quo[k] = '0;
    end
    return r;
  endfunction

  function automatic stage_t div_step(stage_t x, int j);
    stage_t           r;
    logic [DIV_W-1:0] dj;
    r  = x;
    dj = (DIV_W'(x.res[ROOT_W-1:0]) << 1) << j;
    for (int k = 0; k < 4; k++) begin
      if (!x.sat[k] && x.rem[k] >= dj) begin
        r.rem[k]    = x.rem[k] - dj;
        r.quo[k][j] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] finish(logic neg, logic sat,
                                               logic [DATA_W-1:0] q);
    logic [DATA_W-1:0] r;
    if (neg) begin
      if (sat || q > {1'b1, {(DATA_W-1){1'b0}}}) r = {1'b1, {(DATA_W-1){1'b0}}};
      else                                       r = -q;
    end else begin
      if (sat || q[DATA_W-1]) r = {1'b0, {(DATA_W-1){1'b1}}};
      else                    r = q;
    end
    return r;
  endfunction

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    st_d[0] = load(wk_data_i);
    for (int i = 1; i < NST; i++) begin
      if (i <= SQRT_STEPS) begin
        st_d[i] = root_step(st_q[i-1], i - 1);
      end else if (i == SQRT_STEPS + 1) begin
        st_d[i] = div_setup(st_q[i-1]);
      end else begin
        st_d[i] = div_step(st_q[i-1], NST - 1 - i);
      end
    end
  end

  always_comb begin
    stage_t l;
    logic [DATA_W-1:0] q [4];
    l = st_q[NST-1];
    for (int k = 0; k < 4; k++) begin
      q[k] = l.invalid ? '0 : finish(l.neg[k], l.sat[k], l.quo[k][DATA_W-1:0]);
    end
    out_d.qw        = q[0];
    out_d.qx        = q[1];
    out_d.qy        = q[2];
    out_d.qz        = q[3];
    out_d.form_used = l.form;
    out_d.invalid   = l.invalid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= !empty_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
      out_valid_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) st_q[i] <= st_d[i];
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix (row-major, signed Q2.14) to unit quaternion converter.
//
// Input channel: in_valid_i / in_stall_o carry one 3x3 matrix per item in
// in_data_i. Output channel: out_valid_o / out_stall_i carry qw, qx, qy, qz,
// the chosen form and an invalid flag in out_data_o. An item moves when
// valid is high and stall is low at a rising edge.
// Throughput is one item per cycle while out_stall_i is low. The front-end
// register loads at the accepting edge; the item then passes the queue, a
// 34-stage back-end pipeline (a load stage, 16 square-root steps, a divider
// setup stage and 16 quotient-bit steps) and the output register.
// The front end classifies the matrix and forms t and the unscaled
// components; a two-entry queue separates it from the back end.
// When out_stall_i is held, the back-end pipeline freezes and the output
// holds; the queue fills and then in_stall_o rises.
// Reset clears all valid flags and the queue; no item is in flight after it.
// Depends on rmq_pkg, rmq_front, rmq_queue and rmq_back.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  logic  wk_valid, q_full, q_empty, q_pop;
  work_t wk_data, q_data;

  rmq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .wk_valid_o (wk_valid),
    .wk_full_i  (q_full),
    .wk_data_o  (wk_data)
  );

  rmq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (wk_valid),
    .push_data_i (wk_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  rmq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .wk_data_i   (q_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
